[src/rlt_pkg.sv]
// Package for the request line tokenizer: item types, state type, codes
// and the hex digit decoder. No dependencies.
package rlt_pkg;

  localparam logic [7:0] CharPercent  = 8'h25;
  localparam logic [7:0] CharQuestion = 8'h3f;
  localparam logic [7:0] CharSpace    = 8'h20;
  localparam logic [7:0] CharTab      = 8'h09;
  localparam int unsigned NibbleBase  = 16;

  localparam logic [1:0] TagMethod  = 2'd0;
  localparam logic [1:0] TagPath    = 2'd1;
  localparam logic [1:0] TagQuery   = 2'd2;
  localparam logic [1:0] TagVersion = 2'd3;

  localparam logic [2:0] StatusOk        = 3'd0;
  localparam logic [2:0] StatusNoPath    = 3'd1;
  localparam logic [2:0] StatusBadEscape = 3'd2;
  localparam logic [2:0] StatusNoVersion = 3'd3;
  localparam logic [2:0] StatusJunk      = 3'd4;

  localparam logic [1:0] EscIdle  = 2'd0;
  localparam logic [1:0] EscFirst = 2'd1;
  localparam logic [1:0] EscSecond = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_end;
  } in_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic [1:0] field_tag;
    logic       done_res;
    logic [2:0] status;
  } out_t;

  typedef struct packed {
    logic [1:0] separator_count;
    logic [1:0] escape_phase;
    logic [3:0] high_nibble;
    logic       in_query;
    logic       path_terminated;
    logic       escape_error;
  } state_t;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end
    return r;
  endfunction

endpackage

[src/rlt_step.sv]
// Combinational next-state and result logic for one character of the line.
// Depends on rlt_pkg.
module rlt_step import rlt_pkg::*; (
  input  state_t st,
  input  in_t    item,
  output state_t st_next,
  output out_t   res
);

  logic [7:0] c;
  logic       is_sep;
  logic [4:0] hx;
  logic       have;
  logic [7:0] dec;
  state_t     s;

  assign c      = item.in_byte;
  assign is_sep = (c == CharSpace) || (c == CharTab);
  assign hx     = hex_value(c);

  always_comb begin
    s    = st;
    res  = '0;
    have = 1'b0;
    dec  = 8'd0;
    if (is_sep) begin
      if (st.separator_count == 2'd1 && st.escape_phase != EscIdle) begin
        s.escape_error = 1'b1;
        s.escape_phase = EscIdle;
      end
      if (st.separator_count != 2'd3) begin
        s.separator_count = st.separator_count + 2'd1;
      end
    end else if (st.separator_count == 2'd0) begin
      res.out_valid = 1'b1;
      res.out_byte  = c;
      res.field_tag = TagMethod;
    end else if (st.separator_count == 2'd2) begin
      res.out_valid = 1'b1;
      res.out_byte  = c;
      res.field_tag = TagVersion;
    end else if (st.separator_count == 2'd1) begin
      if (st.escape_phase == EscFirst) begin
        if (!hx[4]) begin
          s.escape_error = 1'b1;
          s.escape_phase = EscIdle;
        end else begin
          s.high_nibble  = hx[3:0];
          s.escape_phase = EscSecond;
        end
      end else if (st.escape_phase == EscSecond) begin
        if (!hx[4]) begin
          s.escape_error = 1'b1;
        end else begin
          dec  = 8'(st.high_nibble * NibbleBase) | {4'd0, hx[3:0]};
          have = 1'b1;
        end
        s.escape_phase = EscIdle;
      end else if (c == CharPercent) begin
        s.escape_phase = EscFirst;
      end else begin
        dec  = c;
        have = 1'b1;
      end
      if (have && !s.escape_error && !st.path_terminated) begin
        if (dec == 8'd0) begin
          s.path_terminated = 1'b1;
        end else if (!st.in_query && dec == CharQuestion) begin
          s.in_query = 1'b1;
        end else begin
          res.out_valid = 1'b1;
          res.out_byte  = dec;
          res.field_tag = st.in_query ? TagQuery : TagPath;
        end
      end
    end

    res.done_res = item.line_end;
    if (item.line_end) begin
      if (s.separator_count == 2'd1 && s.escape_phase != EscIdle) begin
        s.escape_error = 1'b1;
      end
      if (s.separator_count == 2'd0) begin
        res.status = StatusNoPath;
      end else if (s.escape_error) begin
        res.status = StatusBadEscape;
      end else if (s.separator_count == 2'd1) begin
        res.status = StatusNoVersion;
      end else if (s.separator_count == 2'd3) begin
        res.status = StatusJunk;
      end else begin
        res.status = StatusOk;
      end
      s = '0;
    end
    st_next = s;
  end

endmodule

[src/request_line_tokenizer.sv]
// Request line tokenizer: splits a request line into method, path, query and
// version tokens, percent-decoding the path. Depends on rlt_pkg and rlt_step.
// The result of an accepted item is written to the output register.
// Throughput: one item per cycle; the only storage is the parse state and the
// single output register, and a new item is taken whenever that register is
// empty or being emptied. Reset clears the parse state and the output valid.
module request_line_tokenizer import rlt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  in_t  req,
  output logic res_valid,
  input  logic res_stall,
  output out_t res
);

  state_t st;
  state_t st_next;
  out_t   step_res;
  logic   accept;

  rlt_step u_step (
    .st      (st),
    .item    (req),
    .st_next (st_next),
    .res     (step_res)
  );

  assign req_stall = res_valid && res_stall;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        st        <= st_next;
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= step_res;
    end
  end

  a_clear_after_line: assert property (@(posedge clk) disable iff (rst)
    (accept && req.line_end) |=> (st == '0))
    else $error("Parse state not cleared after the last item of a line.");

  a_status_only_on_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.done_res) |-> (res.status == StatusOk))
    else $error("Status reported on an item that does not end the line.");

  a_empty_result_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.out_valid) |-> (res.out_byte == 8'd0 && res.field_tag == TagMethod))
    else $error("Result without a token byte carries nonzero byte or tag.");

  a_stall_needs_result: assert property (@(posedge clk)
    req_stall |-> res_valid)
    else $error("Input stalled while the output register is empty.");

endmodule

[test/testbench.sv]
// Self-checking testbench for request_line_tokenizer: random and directed request lines
// go in one byte per item; a scoreboard predicts each tagged output item and checks it.
// Depends on rlt_pkg and the request_line_tokenizer RTL.
module testbench;
  import rlt_pkg::*;

  localparam int HoldCycles = 300;
  localparam int QuietLimit = 2000;

  class token_scoreboard;
    out_t expected_tokens[$];
    int errors;
    logic [1:0] seps;
    logic [1:0] esc_step;
    logic [3:0] esc_high;
    logic query_open;
    logic path_cut;
    logic esc_fail;

    function new();
      errors = 0;
      clear_line();
    endfunction

    function void clear_line();
      seps = 2'd0;
      esc_step = EscIdle;
      esc_high = 4'd0;
      query_open = 1'b0;
      path_cut = 1'b0;
      esc_fail = 1'b0;
    endfunction

    static function int nibble_of(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h57);
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h37);
      return -1;
    endfunction

    function void note_byte(in_t item);
      out_t want;
      int nib;
      logic [7:0] dec;
      logic have;
      want = '0;
      dec = 8'd0;
      have = 1'b0;
      if (item.in_byte == CharSpace || item.in_byte == CharTab) begin
        if (seps == 2'd1 && esc_step != EscIdle) begin
          esc_fail = 1'b1;
          esc_step = EscIdle;
        end
        if (seps != 2'd3) seps = seps + 2'd1;
      end else if (seps == 2'd0) begin
        want.out_valid = 1'b1;
        want.out_byte = item.in_byte;
        want.field_tag = TagMethod;
      end else if (seps == 2'd2) begin
        want.out_valid = 1'b1;
        want.out_byte = item.in_byte;
        want.field_tag = TagVersion;
      end else if (seps == 2'd1) begin
        nib = nibble_of(item.in_byte);
        case (esc_step)
          EscFirst: begin
            if (nib < 0) begin
              esc_fail = 1'b1;
              esc_step = EscIdle;
            end else begin
              esc_high = nib[3:0];
              esc_step = EscSecond;
            end
          end
          EscSecond: begin
            if (nib < 0) begin
              esc_fail = 1'b1;
            end else begin
              dec = 8'(esc_high * NibbleBase + nib);
              have = 1'b1;
            end
            esc_step = EscIdle;
          end
          default: begin
            if (item.in_byte == CharPercent) begin
              esc_step = EscFirst;
            end else begin
              dec = item.in_byte;
              have = 1'b1;
            end
          end
        endcase
        if (have && !esc_fail && !path_cut) begin
          if (dec == 8'd0) begin
            path_cut = 1'b1;
          end else if (!query_open && dec == CharQuestion) begin
            query_open = 1'b1;
          end else begin
            want.out_valid = 1'b1;
            want.out_byte = dec;
            want.field_tag = query_open ? TagQuery : TagPath;
          end
        end
      end
      if (item.line_end) begin
        if (seps == 2'd1 && esc_step != EscIdle) esc_fail = 1'b1;
        want.done_res = 1'b1;
        if (seps == 2'd0) want.status = StatusNoPath;
        else if (esc_fail) want.status = StatusBadEscape;
        else if (seps == 2'd1) want.status = StatusNoVersion;
        else if (seps == 2'd3) want.status = StatusJunk;
        else want.status = StatusOk;
        clear_line();
      end
      expected_tokens.push_back(want);
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_token(out_t got);
      out_t want;
      if (expected_tokens.size() == 0) begin
        $error("result item with no pending input item");
        errors++;
        return;
      end
      want = expected_tokens.pop_front();
      compare("out_valid", 8'(want.out_valid), 8'(got.out_valid));
      compare("out_byte", want.out_byte, got.out_byte);
      compare("field_tag", 8'(want.field_tag), 8'(got.field_tag));
      compare("done_res", 8'(want.done_res), 8'(got.done_res));
      compare("status", 8'(want.status), 8'(got.status));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  in_t req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  out_t res;

  token_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_go = 1'b0;
  int quiet = 0;
  logic [7:0] line_q[$];

  request_line_tokenizer uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_byte(req);
      if (res_valid && !res_stall) sb.check_token(res);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QuietLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : receiver
    int held;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        res_stall <= 1'b1;
        held++;
        if (held == HoldCycles) begin
          hold_go = 1'b0;
          held = 0;
        end
      end else begin
        res_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= '{in_byte: b, line_end: last};
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
  endtask

  task automatic send_line_q();
    for (int i = 0; i < line_q.size(); i++) send_item(line_q[i], i == line_q.size() - 1);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(3) == 0) c = 8'($urandom_range(255, 1));
      else c = 8'($urandom_range(8'h7e, 8'h21));
    end while (c == CharSpace || c == CharTab || c == CharPercent);
    return c;
  endfunction

  function automatic logic [7:0] sep_char();
    return $urandom_range(1) ? CharSpace : CharTab;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + {4'd0, v};
    return ($urandom_range(1) ? 8'h61 : 8'h41) + {4'd0, v} - 8'd10;
  endfunction

  function automatic logic [7:0] bad_hex_char();
    logic [7:0] c;
    do c = plain_char(); while (token_scoreboard::nibble_of(c) >= 0);
    return c;
  endfunction

  task automatic push_path_element();
    logic [7:0] v;
    case ($urandom_range(9))
      0, 1, 2: begin
        if ($urandom_range(4) == 0) begin
          case ($urandom_range(3))
            0: v = 8'h00;
            1: v = CharQuestion;
            2: v = CharSpace;
            default: v = CharPercent;
          endcase
        end else begin
          v = 8'($urandom_range(255));
        end
        line_q.push_back(CharPercent);
        line_q.push_back(hex_char(v[7:4]));
        line_q.push_back(hex_char(v[3:0]));
      end
      3: line_q.push_back(CharQuestion);
      default: line_q.push_back(plain_char());
    endcase
  endtask

  task automatic push_broken_escape();
    line_q.push_back(CharPercent);
    case ($urandom_range(2))
      0: line_q.push_back(bad_hex_char());
      1: begin
        line_q.push_back(hex_char(4'($urandom_range(15))));
        line_q.push_back(bad_hex_char());
      end
      default: ;
    endcase
  endtask

  // Mostly well-formed lines; the rest are noise, lines missing a token,
  // lines with extra separators and junk, and lines with broken escapes.
  task automatic build_random_line();
    int kind;
    int n;
    int bad_at;
    line_q.delete();
    kind = $urandom_range(99);
    if (kind < 12) begin
      n = $urandom_range(20, 1);
      repeat (n) begin
        case ($urandom_range(5))
          0, 1: line_q.push_back(sep_char());
          2: line_q.push_back(CharPercent);
          3: line_q.push_back(hex_char(4'($urandom_range(15))));
          default: line_q.push_back(8'($urandom_range(255, 1)));
        endcase
      end
    end else begin
      n = $urandom_range(6, 1);
      repeat (n) begin
        if ($urandom_range(3) != 0) line_q.push_back(8'($urandom_range(8'h5a, 8'h41)));
        else line_q.push_back(plain_char());
      end
      if (!(kind < 18 && $urandom_range(1) == 0)) begin
        line_q.push_back(sep_char());
        n = $urandom_range(10);
        bad_at = (kind >= 24 && kind < 30) ? int'($urandom_range(n)) : -1;
        for (int i = 0; i <= n; i++) begin
          if (i == bad_at) push_broken_escape();
          else if (i < n) push_path_element();
        end
        if (kind >= 18) begin
          line_q.push_back(sep_char());
          repeat ($urandom_range(8, 1)) line_q.push_back(plain_char());
          if (kind < 24) begin
            repeat ($urandom_range(3, 1)) begin
              line_q.push_back(sep_char());
              repeat ($urandom_range(2)) line_q.push_back(plain_char());
            end
          end
        end
      end
    end
  endtask

  initial begin : stimulus
    int phase_items;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_text("G %4a?%3F\t1");
    send_item(8'hff, 1'b1);
    send_text("  \tj");
    send_text("a %00b%z");
    send_text("a %4");
    send_text("a %zq 1");

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 69; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 69; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      phase_items = 0;
      while (phase_items < 270) begin
        build_random_line();
        send_line_q();
        phase_items += line_q.size();
      end
    end

    // The receiver holds off while lines keep coming, so the block backs up.
    send_idle_pct = 0;
    stall_pct = 0;
    hold_go = 1'b1;
    repeat (4) begin
      build_random_line();
      send_line_q();
    end
    req_valid <= 1'b0;

    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.expected_tokens.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
